// ===== rtl/elias_gamma_signed_encoder_core_macros.svh =====
// Assertion macros shared by the encoder checker.
`ifndef ELIAS_GAMMA_SIGNED_ENCODER_CORE_MACROS_SVH
`define ELIAS_GAMMA_SIGNED_ENCODER_CORE_MACROS_SVH

// Checked on every rising edge outside reset.
`define EGSE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define EGSE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/egse_pkg.sv =====
// Types and constants for the signed Elias gamma encoder.
`timescale 1ns / 1ps

package egse_pkg;

    localparam int BYTE_W = 8;
    localparam int PEND_W = 7;   // held bits, never a whole byte
    localparam int CNT_W  = 3;   // held bit count, 0 to 7

    typedef enum logic [1:0] {
        ST_IDLE,   // waiting for a value
        ST_NORM,   // shifting the code value up to find its width
        ST_EMIT,   // one stream bit per cycle into the byte packer, unless a full byte is stalled
        ST_PAD     // flushing the zero-padded partial byte
    } egse_state_t;

endpackage

// ===== rtl/elias_gamma_signed_encoder_core.sv =====
// Signed Elias gamma encoder with byte-packed output stream.
`timescale 1ns / 1ps

//  channel | dir | tdata                 | tuser | tlast
//  --------+-----+-----------------------+-------+------------------------------
//  s_*     | in  | [31:0] value (signed) | -     | end_of_stream
//  m_*     | out | [7:0]  out_byte       | -     | last_of_run (final byte of item)
//
//  One value at a time. With CW = VALUE_WIDTH + 1 and n the bit width of the code
//  value, an item is accepted, shifted in the normalising shifter, then sent as
//  2n - 1 stream bits through the bit packer, with a padding byte when one is flushed;
//  one stream bit per cycle through the packer, held while a full byte waits on a stall.
//  Reset (rst_n low, asynchronous) empties the held bits and the output register.
//  A stalled m_tready freezes the packer only when a byte is ready to leave.

module elias_gamma_signed_encoder_core #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic        s_tlast,   // end_of_stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic        m_tlast    // last_of_run
);

    // code value is one bit wider than the input
    localparam int CW  = VALUE_WIDTH + 1;
    // bit width counter, holds 1..CW
    localparam int NW  = $clog2(CW + 1);
    // stream bits left for one item, up to 2*CW - 1
    localparam int BLW = $clog2(2 * CW);

    localparam logic [VALUE_WIDTH-1:0] MOST_NEG = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
    localparam logic [VALUE_WIDTH-1:0] MOST_POS = {1'b0, {(VALUE_WIDTH-1){1'b1}}};

    egse_pkg::egse_state_t state_reg, state_next;

    logic [CW-1:0]              code_reg, code_next;
    logic [NW-1:0]              n_reg, n_next;
    logic [BLW-1:0]             bits_left_reg, bits_left_next;
    logic                       eos_reg, eos_next;
    logic [egse_pkg::PEND_W-1:0] pend_bits_reg, pend_bits_next;
    logic [egse_pkg::CNT_W-1:0]  pend_cnt_reg, pend_cnt_next;
    logic                       out_valid_reg, out_valid_next;
    logic [egse_pkg::BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic                       out_last_reg, out_last_next;

    // Value to code mapping: x >= 0 -> 2x + 1, x < 0 -> -2x, most negative saturates.
    logic [VALUE_WIDTH-1:0] raw;
    logic [VALUE_WIDTH-1:0] mag;
    logic [CW-1:0]          in_code;

    always_comb
    begin
        raw = s_tdata[VALUE_WIDTH-1:0];
        mag = (raw == MOST_NEG) ? MOST_POS : (VALUE_WIDTH'(0) - raw);
        in_code = raw[VALUE_WIDTH-1] ? {mag, 1'b0} : {raw, 1'b1};
    end

    // Packer datapath for the current EMIT step.
    logic                        slot_free;
    logic                        code_phase;
    logic                        stream_bit;
    logic [egse_pkg::BYTE_W-1:0] acc;
    logic                        pend_full;
    logic [BLW-1:0]              bits_after;
    logic                        more_bytes;
    logic [egse_pkg::BYTE_W-1:0] pad_byte;

    always_comb
    begin
        slot_free  = !out_valid_reg || m_tready;
        // zeros first, then the normalised code MSB first
        code_phase = !(bits_left_reg > BLW'(n_reg));
        stream_bit = code_phase && code_reg[CW-1];
        acc        = {pend_bits_reg, stream_bit};
        pend_full  = (pend_cnt_reg == egse_pkg::CNT_W'(egse_pkg::PEND_W));
        bits_after = bits_left_reg - BLW'(1);
        // a byte completing now leaves the packer empty
        more_bytes = (bits_after >= BLW'(egse_pkg::BYTE_W))
                     || (eos_reg && (bits_after != BLW'(0)));
        pad_byte   = egse_pkg::BYTE_W'({1'b0, pend_bits_reg}
                     << (4'd8 - {1'b0, pend_cnt_reg}));
    end

    always_comb
    begin
        state_next     = state_reg;
        code_next      = code_reg;
        n_next         = n_reg;
        bits_left_next = bits_left_reg;
        eos_next       = eos_reg;
        pend_bits_next = pend_bits_reg;
        pend_cnt_next  = pend_cnt_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;

        unique case (state_reg)
            egse_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    code_next  = in_code;
                    n_next     = NW'(CW);
                    eos_next   = s_tlast;
                    state_next = egse_pkg::ST_NORM;
                end
            end
            egse_pkg::ST_NORM:
            begin
                // code value is never zero, so the MSB search ends
                if (code_reg[CW-1])
                begin
                    bits_left_next = BLW'({n_reg, 1'b0}) - BLW'(1);
                    state_next     = egse_pkg::ST_EMIT;
                end
                else
                begin
                    code_next = code_reg << 1;
                    n_next    = n_reg - NW'(1);
                end
            end
            egse_pkg::ST_EMIT:
            begin
                if (!pend_full || slot_free)
                begin
                    if (code_phase)
                    begin
                        code_next = code_reg << 1;
                    end
                    if (pend_full)
                    begin
                        out_valid_next = 1'b1;
                        out_byte_next  = acc;
                        out_last_next  = !more_bytes;
                        pend_bits_next = '0;
                        pend_cnt_next  = '0;
                    end
                    else
                    begin
                        pend_bits_next = acc[egse_pkg::PEND_W-1:0];
                        pend_cnt_next  = pend_cnt_reg + egse_pkg::CNT_W'(1);
                    end
                    bits_left_next = bits_after;
                    if (bits_after == BLW'(0))
                    begin
                        state_next = (eos_reg && !pend_full) ? egse_pkg::ST_PAD
                                                             : egse_pkg::ST_IDLE;
                    end
                end
            end
            egse_pkg::ST_PAD:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = pad_byte;
                    out_last_next  = 1'b1;
                    pend_bits_next = '0;
                    pend_cnt_next  = '0;
                    state_next     = egse_pkg::ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= egse_pkg::ST_IDLE;
            pend_bits_reg <= '0;
            pend_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_bits_reg <= pend_bits_next;
            pend_cnt_reg  <= pend_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload and per-item working registers
    always_ff @(posedge clk)
    begin
        code_reg      <= code_next;
        n_reg         <= n_next;
        bits_left_reg <= bits_left_next;
        eos_reg       <= eos_next;
        out_byte_reg  <= out_byte_next;
        out_last_reg  <= out_last_next;
    end

    assign s_tready = (state_reg == egse_pkg::ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== rtl/egse_checker.sv =====
// Port-level checker for the signed Elias gamma encoder, bound to the top level.
`timescale 1ns / 1ps
`include "elias_gamma_signed_encoder_core_macros.svh"

module egse_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        m_tlast
);

    // a waiting byte holds until taken
    `EGSE_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast), "output byte changed while stalled")

    // one value in flight: busy right after a transaction
    `EGSE_ASSERT(a_busy_after_accept, s_tvalid && s_tready |=> !s_tready, "ready straight after accepting a value")

    // an idle block with an empty output makes no byte
    `EGSE_ASSERT(a_idle_no_byte, s_tready && !m_tvalid |=> !m_tvalid, "byte appeared while idle")

    // an edge seen in reset leaves the output register empty
    `EGSE_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !m_tvalid, "output valid after a reset edge")

endmodule

bind elias_gamma_signed_encoder_core egse_checker u_egse_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// ===== tb/elias_gamma_signed_encoder_core_tb.sv =====
// Self-checking testbench for the signed Elias gamma encoder core.
`timescale 1ns / 1ps

module elias_gamma_signed_encoder_core_tb;

    localparam int QUIET_LIMIT = 4000;  // cycles with no transaction before giving up
    localparam int TAIL_CYCLES = 150;   // worst item is well under this
    localparam int HOLD_CYCLES = 400;   // long receiver hold-off

    typedef struct packed {
        logic [egse_pkg::BYTE_W-1:0] out_byte;
        logic                        last_of_run;
    } coded_byte_t;

    // Bit-level model of the encoder plus the queue of bytes still owed.
    class gamma_byte_board;
        coded_byte_t                 due[$];
        coded_byte_t                 run_bytes[$];
        logic [egse_pkg::PEND_W-1:0] held_bits;
        logic [egse_pkg::CNT_W-1:0]  held_count;
        int errors;
        int values_seen;
        int eos_seen;
        int bytes_checked;
        int runs_checked;

        function new();
            held_bits  = '0;
            held_count = '0;
        endfunction

        function int waiting();
            return due.size();
        endfunction

        // One stream bit into the packer; a full byte goes to run_bytes.
        function void shift_bit(logic b);
            if (held_count == 3'd7)
            begin
                run_bytes.push_back('{out_byte: {held_bits, b}, last_of_run: 1'b0});
                held_bits  = '0;
                held_count = '0;
            end
            else
            begin
                held_bits  = {held_bits[5:0], b};
                held_count = held_count + 3'd1;
            end
        endfunction

        function void note_value(logic [31:0] value, logic eos);
            logic [31:0] mag;
            logic [63:0] code;
            int          nbits;
            values_seen++;
            if (eos)
                eos_seen++;
            // Zigzag-style mapping; the most negative value saturates.
            if (value[31])
            begin
                mag = 32'd0 - value;
                if (mag[31])
                    mag = 32'h7FFF_FFFF;
                code = {31'd0, mag, 1'b0};
            end
            else
            begin
                code = {31'd0, value, 1'b1};
            end
            nbits = 0;
            for (int i = 0; i < 64; i++)
                if (code[i])
                    nbits = i + 1;
            run_bytes.delete();
            for (int i = 1; i < nbits; i++)
                shift_bit(1'b0);
            for (int i = nbits - 1; i >= 0; i--)
                shift_bit(code[i]);
            // Padding only when something is actually held.
            if (eos)
                while (held_count != '0)
                    shift_bit(1'b0);
            if (run_bytes.size() > 0)
            begin
                run_bytes[run_bytes.size() - 1].last_of_run = 1'b1;
                foreach (run_bytes[i])
                    due.push_back(run_bytes[i]);
            end
        endfunction

        function void check_byte(logic [7:0] got_byte, logic got_last);
            coded_byte_t want;
            if (due.size() == 0)
            begin
                $error("unexpected output transaction: out_byte %02h last_of_run %0b",
                       got_byte, got_last);
                errors++;
                return;
            end
            want = due.pop_front();
            bytes_checked++;
            if (got_last === 1'b1)
                runs_checked++;
            if (got_byte !== want.out_byte)
            begin
                $error("out_byte: expected %02h, got %02h", want.out_byte, got_byte);
                errors++;
            end
            if (got_last !== want.last_of_run)
            begin
                $error("last_of_run: expected %0b, got %0b", want.last_of_run, got_last);
                errors++;
            end
        endfunction
    endclass

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;

    gamma_byte_board board = new();

    int send_idle_pct = 0;    // sender: chance of a gap before each transaction
    int recv_idle_pct = 0;    // receiver: chance of dropping tready per cycle
    logic rx_hold = 1'b0;     // forces tready low during the long hold-off
    int quiet_cycles = 0;

    elias_gamma_signed_encoder_core #(
        .VALUE_WIDTH(32)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver: random back-pressure, overridden by the hold-off.
    always @(posedge clk)
        m_tready <= !rx_hold && ($urandom_range(99) >= recv_idle_pct);

    // Monitor: both channels sampled at the edge where the transaction happens.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                board.note_value(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
                board.check_byte(m_tdata, m_tlast);
        end
    end

    // Watchdog: quiet spell on both channels means the block has hung.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Timed out after %0d idle cycles", quiet_cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    // One input transaction; s_tvalid stays high into the next call unless it idles.
    task automatic send_value(input logic [31:0] value, input logic eos);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tlast  <= eos;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (board.waiting() != 0)
            @(posedge clk);
    endtask

    // Mix of tiny, mid-width and near-full-scale magnitudes, either sign.
    function automatic logic [31:0] pick_value();
        logic [31:0] mag;
        if ($urandom_range(39) == 0)
            return 32'h8000_0000;
        case ($urandom_range(7))
            0:       mag = $urandom_range(15);
            1, 2:    mag = $urandom() >> $urandom_range(31);
            3:       mag = 32'h7FFF_FFFF >> $urandom_range(3);
            default: return $urandom();
        endcase
        mag[31] = 1'b0;
        return $urandom_range(1) ? (32'd0 - mag) : mag;
    endfunction

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++)
            send_value(pick_value(), $urandom_range(3) == 0);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: held-bit bookkeeping is tracked in the notes.
        send_value(32'd0, 1'b0);            // 1 bit, no byte completed
        send_value(32'd4, 1'b1);            // 7 bits fill the byte, nothing left to pad
        send_value(32'd4, 1'b0);            // 7 held bits
        send_value(32'h7FFF_FFFF, 1'b1);    // 63 bits on 7 held plus pad: nine bytes
        send_value(32'h8000_0001, 1'b1);    // most negative legal value
        send_value(32'h8000_0000, 1'b0);    // saturates to the value above
        send_value(32'hFFFF_FFFF, 1'b0);    // -1
        send_value(32'd1, 1'b1);
        send_value(32'h4000_0000, 1'b0);
        send_value(32'hC000_0000, 1'b0);
        send_value(32'h5555_5555, 1'b1);
        send_value(32'hAAAA_AAAA, 1'b0);
        send_value(32'h0000_FFFF, 1'b0);
        send_value(32'hFFFF_0000, 1'b1);
        send_value(32'd63, 1'b0);
        send_value(32'hFFFF_FFC0, 1'b0);    // -64
        send_value(32'hFFFF_FFFE, 1'b0);    // -2
        send_value(32'd2, 1'b1);
        wait_for_drain();

        send_idle_pct = 29;
        recv_idle_pct <= 58;
        send_random(90);
        wait_for_drain();

        send_idle_pct = 58;
        recv_idle_pct <= 29;
        send_random(90);
        wait_for_drain();

        send_idle_pct = 0;
        recv_idle_pct <= 0;
        send_random(60);

        // Long receiver stall while values keep coming, so the input backs up.
        fork
            begin
                rx_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                rx_hold <= 1'b0;
            end
        join_none
        send_random(30);
        send_value(pick_value(), 1'b1);
        wait_for_drain();

        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Encoded %0d values (%0d with end of stream); checked %0d bytes in %0d runs",
                 board.values_seen, board.eos_seen, board.bytes_checked, board.runs_checked);
        $display("Covered extremes, saturation, padding, empty runs and heavy back-pressure");
        if (board.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/egse_pkg.sv
rtl/elias_gamma_signed_encoder_core.sv
rtl/egse_checker.sv
tb/elias_gamma_signed_encoder_core_tb.sv
